// ----- hw/rtl/pcmks_pkg.sv -----
// Shared types and constants for the packed column multi-key scan.
package pcmks_pkg;

  localparam int GROUP_VALUES = 8;
  localparam int GROUP_BITS   = 64;
  localparam int KEY_BITS     = 8;
  localparam int SLOT_BITS    = 6;
  localparam int COUNT_BITS   = 7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } scan_state_t;

endpackage

// ----- hw/rtl/pcmks_keymem.sv -----
// Key table memory with one write port and one registered read port.
module pcmks_keymem import pcmks_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [KEY_BITS-1:0] wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [KEY_BITS-1:0] rd_data
);

  logic [KEY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pcmks_lane.sv -----
// One compare lane: checks one packed value against the current key.
module pcmks_lane import pcmks_pkg::*; #(
  parameter int VALUE_BITS = 8
) (
  input  logic [VALUE_BITS-1:0] value,
  input  logic [KEY_BITS-1:0]   key,
  output logic                  hit
);

  logic [KEY_BITS-1:0] value_ext;

  assign value_ext = KEY_BITS'(value);
  assign hit       = (value_ext == key);

endmodule

// ----- hw/rtl/packed_column_multi_key_scan_top.sv -----
// Top level of the packed column multi-key scan: sequencer, key table, lanes, merge.
// Pipeline: key table read into s1, lane compares registered into the outputs; one result
// per cycle while out_stall is low. A scan reads key_count keys (capped at KEY_SLOTS) via the
// single read port of the key table and holds in_stall high until its last read.
// Reset: rst is synchronous, active high; clears control state and sets key_count to 8.
// The key table is not cleared; keys must be loaded before they are scanned.
module packed_column_multi_key_scan_top import pcmks_pkg::*; #(
  parameter int VALUE_BITS = 8,
  parameter int KEY_SLOTS  = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [SLOT_BITS-1:0]  key_slot,
  input  logic [KEY_BITS-1:0]   key_value,
  input  logic [GROUP_BITS-1:0] packed_group,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SLOT_BITS-1:0]  key_index,
  output logic [GROUP_VALUES-1:0] match_mask,
  output logic                  last_of_group
);

  localparam int ADDR_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [COUNT_BITS-1:0] SLOTS_C = COUNT_BITS'(KEY_SLOTS);

  scan_state_t state, state_next;

  logic [COUNT_BITS-1:0] key_count;
  logic [COUNT_BITS-1:0] used;
  logic [COUNT_BITS-1:0] used_in;
  logic [SLOT_BITS-1:0]  rd_ptr;
  logic [GROUP_BITS-1:0] group_q;

  logic                  s1_valid;
  logic [SLOT_BITS-1:0]  s1_idx;
  logic                  s1_last;
  logic [GROUP_BITS-1:0] s1_group;
  logic [KEY_BITS-1:0]   s1_key;

  logic in_xfer, out_free, s1_free, rd_en, rd_last;
  logic load_en, scan_start;
  logic [GROUP_VALUES-1:0] hits;

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign s1_free    = !s1_valid || out_free;
  assign used_in    = (key_count > SLOTS_C) ? SLOTS_C : key_count;
  assign load_en    = in_xfer && (action == ACT_LOAD) &&
                      ({1'b0, key_slot} < SLOTS_C);
  assign scan_start = in_xfer && (action == ACT_SCAN) && (used_in != '0);
  assign rd_last    = (COUNT_BITS'(rd_ptr) + COUNT_BITS'(1)) == used;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (scan_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en && rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b0;
    rd_en    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_en    = 1'b0;
      end
      ST_SCAN: begin
        in_stall = 1'b1;
        rd_en    = s1_free;
      end
      default: begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= COUNT_BITS'(8);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        key_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      used    <= used_in;
      group_q <= packed_group;
      rd_ptr  <= '0;
    end else if (rd_en) begin
      rd_ptr <= rd_ptr + SLOT_BITS'(1);
    end
  end

  pcmks_keymem #(
    .DEPTH  (KEY_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_keymem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (key_slot[ADDR_W-1:0]),
    .wr_data (key_value),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[ADDR_W-1:0]),
    .rd_data (s1_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_idx   <= rd_ptr;
      s1_last  <= rd_last;
      s1_group <= group_q;
    end
  end

  for (genvar i = 0; i < GROUP_VALUES; i++) begin : g_lane
    pcmks_lane #(
      .VALUE_BITS (VALUE_BITS)
    ) u_lane (
      .value (s1_group[i*VALUE_BITS +: VALUE_BITS]),
      .key   (s1_key),
      .hit   (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      key_index     <= s1_idx;
      match_mask    <= hits;
      last_of_group <= s1_last;
    end
  end

endmodule
